// File: hdl/tcw_pkg.sv
// Shared types and constants of the text console writer.
package tcw_pkg;

   // Operation codes of an input item
   localparam logic OP_PUT  = 1'b0;
   localparam logic OP_READ = 1'b1;

   // Character codes with a meaning of their own
   localparam logic [7:0] CHAR_NUL       = 8'h00;
   localparam logic [7:0] CHAR_BACKSPACE = 8'h08;
   localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
   localparam logic [7:0] CHAR_BLANK     = 8'h20;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_PRIME,
      ST_SCROLL
   } state_type;

   // Store write request and scroll demand raised by the cursor unit
   typedef struct packed {
      logic write;
      logic scroll;
   } put_ctl_type;

endpackage

// File: hdl/tcw_ram.sv
// Generic single-clock RAM, one write port and one registered read port.
module tcw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read, old data on a same-address write
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/tcw_cursor.sv
// Cursor unit: row, column and linear position, and the store write of a put.
module tcw_cursor #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               put_en,
   input  logic [7:0]                         character,
   output tcw_pkg::put_ctl_type               ctl,
   output logic [$clog2(ROWS*COLUMNS)-1:0]    wr_addr,
   output logic [7:0]                         wr_data,
   output logic [$clog2(ROWS*COLUMNS)-1:0]    cursor_pos
);
   import tcw_pkg::*;

   localparam int POS_W = $clog2(ROWS*COLUMNS);
   localparam int ROW_W = $clog2(ROWS);
   localparam int COL_W = $clog2(COLUMNS);
   localparam int LAST_ROW_START = (ROWS - 1) * COLUMNS;

   logic [ROW_W-1:0] row_ff, row_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [POS_W-1:0] pos_ff, pos_in;

   // Next cursor and store write for one put
   always_comb begin
      logic last_col;
      logic last_row;
      logic next_row;
      last_col = (col_ff == COL_W'(COLUMNS - 1));
      last_row = (row_ff == ROW_W'(ROWS - 1));
      next_row = 1'b0;
      row_in   = row_ff;
      col_in   = col_ff;
      pos_in   = pos_ff;
      ctl      = '0;
      wr_addr  = pos_ff;
      wr_data  = character;
      if (put_en) begin
         case (character)
            CHAR_NUL: begin
            end
            CHAR_BACKSPACE: begin
               if (col_ff != '0) begin
                  col_in    = col_ff - COL_W'(1);
                  pos_in    = pos_ff - POS_W'(1);
                  ctl.write = 1'b1;
                  wr_addr   = pos_ff - POS_W'(1);
                  wr_data   = CHAR_BLANK;
               end
            end
            default: begin
               if (character == CHAR_NEWLINE) begin
                  next_row = 1'b1;
               end else begin
                  ctl.write = 1'b1;
                  if (last_col) begin
                     next_row = 1'b1;
                  end else begin
                     col_in = col_ff + COL_W'(1);
                     pos_in = pos_ff + POS_W'(1);
                  end
               end
            end
         endcase
         // Start of the next row, scrolling from the last one
         if (next_row) begin
            col_in = '0;
            if (last_row) begin
               ctl.scroll = 1'b1;
               pos_in     = POS_W'(LAST_ROW_START);
            end else begin
               row_in = row_ff + ROW_W'(1);
               pos_in = pos_ff + (POS_W'(COLUMNS) - POS_W'(col_ff));
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
         pos_ff <= '0;
      end else begin
         row_ff <= row_in;
         col_ff <= col_in;
         pos_ff <= pos_in;
      end
   end

   assign cursor_pos = pos_ff;

endmodule

// File: hdl/text_console_writer.sv
// Text console writer top level: character store, cursor unit and sequencer.
//
// Usage:
//   An item is taken at a rising edge with start high and busy low. With
//   req_operation = put, req_character is written at the cursor (0 ignored,
//   backspace and newline move the cursor); with req_operation = read, the
//   cell at req_read_row / req_read_col is fetched (0 outside the screen).
//   Every item gives one result, shown for one cycle with rsp_strobe high:
//   the cursor after the item, the cell read and whether the screen scrolled.
//   The receiver cannot stall; results are simply presented.
// Timing:
//   A put without scroll is done when taken, the result strobing in the next cycle.
//   A read passes through ST_READ, as the read port of the store is registered.
//   A put that scrolls passes through ST_PRIME and ST_SCROLL: the store
//   is swept one cell a cycle, copying each row up and blanking the last.
// Reset:
//   Cursor goes to 0 and a clearing pass writes spaces into all ROWS*COLUMNS
//   cells, one per cycle; busy is high throughout.
module text_console_writer #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic                             req_operation,
   input  logic [7:0]                       req_character,
   input  logic [$clog2(ROWS)-1:0]          req_read_row,
   input  logic [$clog2(COLUMNS)-1:0]       req_read_col,
   output logic                             rsp_strobe,
   output logic [$clog2(ROWS*COLUMNS)-1:0]  rsp_cursor_pos,
   output logic [7:0]                       rsp_cell_char,
   output logic                             rsp_scrolled
);
   import tcw_pkg::*;

   localparam int CELLS = ROWS * COLUMNS;
   localparam int POS_W = $clog2(CELLS);
   localparam int ROW_W = $clog2(ROWS);
   localparam int COL_W = $clog2(COLUMNS);

   state_type        state_ff, state_in;
   logic [POS_W-1:0] idx_ff, idx_in;
   logic             oob_ff, oob_in;
   logic             rsp_strobe_ff, rsp_strobe_in;
   logic [7:0]       rsp_cell_ff, rsp_cell_in;
   logic             rsp_scrolled_ff, rsp_scrolled_in;

   logic             accept;
   logic             put_en;
   put_ctl_type      put_ctl;
   logic [POS_W-1:0] cur_wr_addr;
   logic [7:0]       cur_wr_data;
   logic [POS_W-1:0] cur_pos;

   logic             ram_we;
   logic [POS_W-1:0] ram_waddr;
   logic [7:0]       ram_wdata;
   logic [POS_W-1:0] ram_raddr;
   logic [7:0]       ram_rdata;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;
   assign put_en = accept && (req_operation == OP_PUT);

   tcw_cursor #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_cursor (
      .clock      (clock),
      .reset      (reset),
      .put_en     (put_en),
      .character  (req_character),
      .ctl        (put_ctl),
      .wr_addr    (cur_wr_addr),
      .wr_data    (cur_wr_data),
      .cursor_pos (cur_pos)
   );

   tcw_ram #(
      .WIDTH (8),
      .DEPTH (CELLS)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // Sequencer: next state, store access and result
   always_comb begin
      logic [POS_W:0] src_next;
      src_next        = {1'b0, idx_ff} + (POS_W+1)'(COLUMNS + 1);
      state_in        = state_ff;
      idx_in          = idx_ff;
      oob_in          = oob_ff;
      rsp_strobe_in   = 1'b0;
      rsp_cell_in     = rsp_cell_ff;
      rsp_scrolled_in = rsp_scrolled_ff;
      ram_we          = 1'b0;
      ram_waddr       = idx_ff;
      ram_wdata       = CHAR_BLANK;
      ram_raddr       = POS_W'(req_read_row) * POS_W'(COLUMNS) + POS_W'(req_read_col);
      unique case (state_ff)
         ST_CLEAR: begin
            ram_we = 1'b1;
            idx_in = idx_ff + POS_W'(1);
            if (idx_ff == POS_W'(CELLS - 1)) begin
               idx_in   = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               if (req_operation == OP_READ) begin
                  oob_in   = ({1'b0, req_read_row} >= (ROW_W+1)'(ROWS)) ||
                             ({1'b0, req_read_col} >= (COL_W+1)'(COLUMNS));
                  state_in = ST_READ;
               end else begin
                  ram_we    = put_ctl.write;
                  ram_waddr = cur_wr_addr;
                  ram_wdata = cur_wr_data;
                  if (put_ctl.scroll) begin
                     idx_in   = '0;
                     state_in = ST_PRIME;
                  end else begin
                     rsp_strobe_in   = 1'b1;
                     rsp_cell_in     = CHAR_NUL;
                     rsp_scrolled_in = 1'b0;
                  end
               end
            end
         end
         ST_READ: begin
            rsp_strobe_in   = 1'b1;
            rsp_cell_in     = oob_ff ? CHAR_NUL : ram_rdata;
            rsp_scrolled_in = 1'b0;
            state_in        = ST_IDLE;
         end
         ST_PRIME: begin
            // first source cell is the start of row one
            ram_raddr = POS_W'(COLUMNS);
            state_in  = ST_SCROLL;
         end
         ST_SCROLL: begin
            ram_we    = 1'b1;
            ram_wdata = (idx_ff < POS_W'(CELLS - COLUMNS)) ? ram_rdata : CHAR_BLANK;
            ram_raddr = (src_next < (POS_W+1)'(CELLS)) ? src_next[POS_W-1:0] : '0;
            idx_in    = idx_ff + POS_W'(1);
            if (idx_ff == POS_W'(CELLS - 1)) begin
               idx_in          = '0;
               rsp_strobe_in   = 1'b1;
               rsp_cell_in     = CHAR_NUL;
               rsp_scrolled_in = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         idx_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      oob_ff          <= oob_in;
      rsp_cell_ff     <= rsp_cell_in;
      rsp_scrolled_ff <= rsp_scrolled_in;
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_cell_char  = rsp_cell_ff;
   assign rsp_scrolled   = rsp_scrolled_ff;
   assign rsp_cursor_pos = cur_pos;

endmodule
